// ===== src/mmva_pkg.sv =====
// ----------------------------------------------------------------------------
// mmva_pkg
// shared constants for the monophonic midi voice assigner
// ----------------------------------------------------------------------------
package mmva_pkg;

  localparam int NOTE_SLOTS = 128;
  localparam int ROW_W      = 8;
  localparam int MAP_ROWS   = NOTE_SLOTS / ROW_W;
  localparam int ROW_IDX_W  = (MAP_ROWS > 1) ? $clog2(MAP_ROWS) : 1;
  localparam int BIT_IDX_W  = $clog2(ROW_W);

  localparam int NOTE_W  = 7;
  localparam int PITCH_W = 8;
  localparam int VEL_W   = 7;
  localparam int BEND_W  = 14;
  localparam int COUNT_W = 7;

  localparam logic [PITCH_W-1:0] NO_NOTE     = 8'd128;
  localparam logic [BEND_W-1:0]  BEND_CENTER = 14'd8192;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 7'd127;

  localparam logic CMD_MIDI  = 1'b0;
  localparam logic CMD_PANIC = 1'b1;

  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;
  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
  localparam logic [3:0] MSG_BEND     = 4'hE;

  typedef logic [ROW_W-1:0] map_row_t;

endpackage

// ===== src/midi_mono_voice_assigner_unit.sv =====
// ----------------------------------------------------------------------------
// midi_mono_voice_assigner_unit
// Monophonic voice assigner: each note-on takes the voice and retriggers;
// releasing the sounding note while others are held gives the lowest one. One
// request is a three-byte midi message (channel ignored) or a panic, and
// gives one result with the pitch, velocity, bend, gate, retrigger and
// release pulses and the held-note count. The held-note map is a synchronous
// memory of rows of eight bits, each row with a valid bit so reset and panic
// clear it at once. Panic, bend and other messages go straight to the result
// state; note-on and note-off first read the row, then modify and write it
// back. A note-off that releases the sounding note while others are held
// scans the map row by row, lowest row first. One request is in work at a
// time; a new one is taken once the last result is in the output register.
// ----------------------------------------------------------------------------
module midi_mono_voice_assigner_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_command,
  input  logic [7:0]                     in_status_byte,
  input  logic [mmva_pkg::NOTE_W-1:0]    in_data_first,
  input  logic [mmva_pkg::NOTE_W-1:0]    in_data_second,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mmva_pkg::PITCH_W-1:0]   out_sounding_pitch,
  output logic [mmva_pkg::VEL_W-1:0]     out_note_velocity,
  output logic [mmva_pkg::BEND_W-1:0]    out_bend_value,
  output logic                           out_gate,
  output logic                           out_key_on,
  output logic                           out_key_off,
  output logic [mmva_pkg::COUNT_W-1:0]   out_held_count
);
  import mmva_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_READ     = 6'b000010,
    ST_MOD      = 6'b000100,
    ST_SCAN_RD  = 6'b001000,
    ST_SCAN_CHK = 6'b010000,
    ST_DONE     = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [MAP_ROWS-1:0]    row_valid_r, row_valid_nxt;
  logic [COUNT_W-1:0]     held_total_r, held_total_nxt;
  logic [PITCH_W-1:0]     current_note_r, current_note_nxt;
  logic [VEL_W-1:0]       last_vel_r, last_vel_nxt;
  logic [BEND_W-1:0]      bend_r, bend_nxt;
  logic                   gate_r, gate_nxt;
  logic                   key_on_r, key_on_nxt;
  logic                   key_off_r, key_off_nxt;
  logic                   note_on_r, note_on_nxt;
  logic [NOTE_W-1:0]      note_r, note_nxt;
  logic [ROW_IDX_W-1:0]   scan_row_r, scan_row_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [PITCH_W-1:0]     out_pitch_r;
  logic [VEL_W-1:0]       out_vel_r;
  logic [BEND_W-1:0]      out_bend_r;
  logic                   out_gate_r;
  logic                   out_key_on_r;
  logic                   out_key_off_r;
  logic [COUNT_W-1:0]     out_count_r;
  logic                   out_load;

  map_row_t               map_mem [MAP_ROWS];
  map_row_t               rd_data_r;
  logic                   rd_valid_r;
  logic [ROW_IDX_W-1:0]   rd_addr;
  logic                   mem_we;
  map_row_t               mem_wdata;

  logic [3:0]             in_kind;
  logic                   accept;
  logic [ROW_IDX_W-1:0]   note_row;
  logic [BIT_IDX_W-1:0]   note_bit;
  logic                   note_in_range;
  map_row_t               row_data;
  map_row_t               row_mod;

  function automatic logic [BIT_IDX_W-1:0] lowest_bit(input map_row_t v);
    logic [BIT_IDX_W-1:0] idx;
    idx = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = BIT_IDX_W'(i);
      end
    end
    return idx;
  endfunction

  assign in_kind       = in_status_byte[7:4];
  assign in_ready      = (state_r == ST_IDLE);
  assign accept        = in_valid && in_ready;
  assign note_row      = note_r[ROW_IDX_W+BIT_IDX_W-1:BIT_IDX_W];
  assign note_bit      = note_r[BIT_IDX_W-1:0];
  assign note_in_range = PITCH_W'(note_r) < PITCH_W'(NOTE_SLOTS);
  assign row_data      = rd_valid_r ? rd_data_r : '0;

  always_comb begin
    row_mod           = row_data;
    row_mod[note_bit] = note_on_r;
  end

  always_comb begin
    state_nxt        = state_r;
    row_valid_nxt    = row_valid_r;
    held_total_nxt   = held_total_r;
    current_note_nxt = current_note_r;
    last_vel_nxt     = last_vel_r;
    bend_nxt         = bend_r;
    gate_nxt         = gate_r;
    key_on_nxt       = key_on_r;
    key_off_nxt      = key_off_r;
    note_on_nxt      = note_on_r;
    note_nxt         = note_r;
    scan_row_nxt     = scan_row_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_load         = 1'b0;
    mem_we           = 1'b0;
    mem_wdata        = row_mod;
    rd_addr          = (state_r == ST_SCAN_RD) ? scan_row_r : note_row;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          key_on_nxt  = 1'b0;
          key_off_nxt = 1'b0;
          note_nxt    = in_data_first;
          note_on_nxt = (in_kind == MSG_NOTE_ON) && (in_data_second != '0);
          state_nxt   = ST_DONE;
          if (in_command == CMD_PANIC) begin
            row_valid_nxt  = '0;
            held_total_nxt = '0;
            gate_nxt       = 1'b0;
            key_off_nxt    = 1'b1;
          end else if (in_kind == MSG_NOTE_ON) begin
            last_vel_nxt = (in_data_second != '0) ? in_data_second : last_vel_r;
            state_nxt    = ST_READ;
          end else if (in_kind == MSG_NOTE_OFF) begin
            state_nxt = ST_READ;
          end else if (in_kind == MSG_BEND) begin
            bend_nxt = {in_data_second, in_data_first};
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_MOD;
      end
      ST_MOD: begin
        state_nxt = ST_DONE;
        if (note_in_range) begin
          mem_we                  = 1'b1;
          row_valid_nxt[note_row] = 1'b1;
        end
        if (note_on_r) begin
          current_note_nxt = PITCH_W'(note_r);
          key_on_nxt       = 1'b1;
          gate_nxt         = 1'b1;
          if (held_total_r < COUNT_MAX) begin
            held_total_nxt = held_total_r + COUNT_W'(1);
          end
        end else if (held_total_r <= COUNT_W'(1)) begin
          held_total_nxt = '0;
          gate_nxt       = 1'b0;
          key_off_nxt    = 1'b1;
        end else begin
          held_total_nxt = held_total_r - COUNT_W'(1);
          if (PITCH_W'(note_r) == current_note_r) begin
            scan_row_nxt = '0;
            state_nxt    = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        if (row_data != '0) begin
          current_note_nxt = PITCH_W'({scan_row_r, lowest_bit(row_data)});
          state_nxt        = ST_DONE;
        end else if (scan_row_r == ROW_IDX_W'(MAP_ROWS - 1)) begin
          current_note_nxt = NO_NOTE;
          state_nxt        = ST_DONE;
        end else begin
          scan_row_nxt = scan_row_r + ROW_IDX_W'(1);
          state_nxt    = ST_SCAN_RD;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      row_valid_r    <= '0;
      held_total_r   <= '0;
      current_note_r <= '0;
      last_vel_r     <= '0;
      bend_r         <= BEND_CENTER;
      gate_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      row_valid_r    <= row_valid_nxt;
      held_total_r   <= held_total_nxt;
      current_note_r <= current_note_nxt;
      last_vel_r     <= last_vel_nxt;
      bend_r         <= bend_nxt;
      gate_r         <= gate_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_on_r   <= key_on_nxt;
    key_off_r  <= key_off_nxt;
    note_on_r  <= note_on_nxt;
    note_r     <= note_nxt;
    scan_row_r <= scan_row_nxt;
    if (out_load) begin
      out_pitch_r   <= current_note_r;
      out_vel_r     <= last_vel_r;
      out_bend_r    <= bend_r;
      out_gate_r    <= gate_r;
      out_key_on_r  <= key_on_r;
      out_key_off_r <= key_off_r;
      out_count_r   <= held_total_r;
    end
  end

  // held-note map rows
  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[note_row] <= mem_wdata;
    end
    rd_data_r  <= map_mem[rd_addr];
    rd_valid_r <= row_valid_r[rd_addr];
  end

  assign out_valid          = out_valid_r;
  assign out_sounding_pitch = out_pitch_r;
  assign out_note_velocity  = out_vel_r;
  assign out_bend_value     = out_bend_r;
  assign out_gate           = out_gate_r;
  assign out_key_on         = out_key_on_r;
  assign out_key_off        = out_key_off_r;
  assign out_held_count     = out_count_r;

  a_gate_tracks_count: assert property (@(posedge clk) disable iff (!rst_n)
    gate_r == (held_total_r != '0))
    else $error("gate flag disagrees with held count");

  a_scan_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN_CHK |-> $past(state_r) == ST_SCAN_RD)
    else $error("scan check without a row read");

  a_scan_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN_CHK |-> 32'(scan_row_r) <= 32'(MAP_ROWS - 1))
    else $error("scan row past end of map");

  a_pulses_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_key_on_r && out_key_off_r))
    else $error("retrigger and release in one result");

endmodule
